// File: rtl/script_content_filter_unit_macros.svh
// Assertion helpers for the script content filter.
`ifndef SCRIPT_CONTENT_FILTER_UNIT_MACROS_SVH
`define SCRIPT_CONTENT_FILTER_UNIT_MACROS_SVH

// Checked at every clock edge outside reset.
`define SCF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SCF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/scf_pkg.sv
`default_nettype none

package scf_pkg;

   localparam logic [2:0] CAUSE_NONE    = 3'd0;
   localparam logic [2:0] CAUSE_SCRIPT  = 3'd1;
   localparam logic [2:0] CAUSE_SCHEME  = 3'd2;
   localparam logic [2:0] CAUSE_IFRAME  = 3'd3;
   localparam logic [2:0] CAUSE_OBJECT  = 3'd4;
   localparam logic [2:0] CAUSE_EMBED   = 3'd5;
   localparam logic [2:0] CAUSE_HANDLER = 3'd6;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_LT  = 8'h3c;
   localparam logic [7:0] CH_EQ  = 8'h3d;
   localparam logic [7:0] CH_GT  = 8'h3e;
   localparam logic [7:0] CH_N   = 8'h6e;
   localparam logic [7:0] CH_O   = 8'h6f;

   // Patterns packed with the first character in the low byte.
   localparam logic [87:0] PAT_SCRIPT = {32'h0, "tpircs<"};
   localparam logic [87:0] PAT_SCHEME = ":tpircsavaj";
   localparam logic [87:0] PAT_IFRAME = {32'h0, "emarfi<"};
   localparam logic [87:0] PAT_OBJECT = {32'h0, "tcejbo<"};
   localparam logic [87:0] PAT_EMBED  = {40'h0, "debme<"};

   localparam logic [3:0] LEN_SCRIPT = 4'd7;
   localparam logic [3:0] LEN_SCHEME = 4'd11;
   localparam logic [3:0] LEN_IFRAME = 4'd7;
   localparam logic [3:0] LEN_OBJECT = 4'd7;
   localparam logic [3:0] LEN_EMBED  = 4'd6;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_WS     = 6'b000010,
      PH_O      = 6'b000100,
      PH_ON     = 6'b001000,
      PH_NAME   = 6'b010000,
      PH_POSTWS = 6'b100000
   } handler_phase_type;

   typedef struct packed {
      logic [3:0] pos;
      logic       hit;
   } match_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c >= 8'h61 && c <= 8'h7a;
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == 8'h2d || c == 8'h5f;
   endfunction

   // Prefix matcher step; the first pattern character occurs only once.
   function automatic match_type match_step(input logic [3:0]  pos,
                                            input logic [7:0]  c,
                                            input logic [87:0] pat,
                                            input logic [3:0]  len);
      match_type r;
      r.hit = 1'b0;
      if (pos < len && c == pat[{pos, 3'b000} +: 8]) begin
         r.pos = pos + 4'd1;
      end else begin
         r.pos = (c == pat[7:0]) ? 4'd1 : 4'd0;
      end
      if (r.pos >= len) begin
         r.hit = 1'b1;
         r.pos = 4'd0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/script_content_filter_unit.sv
// Script content filter: screens a document for the no-script profile.
// Send the document one byte per request, last_byte high on the final byte
// (documents hold at least one byte). Letters are folded to lower case; on
// the final byte one response reports violation and cause, first hit in
// priority order: script tag, javascript scheme (whitespace and NUL
// skipped), iframe, object, embed, inline handler in a closed tag. With
// the profile register clear at the final byte every document passes. One
// byte per cycle sustained: bytes land in an input register, a single pass
// of small match counters updates state, and the response sits in an
// output register. A final byte waits in the input register only while an
// older response is stalled.
`default_nettype none

`include "script_content_filter_unit_macros.svh"

module script_content_filter_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_doc_byte,
   input  wire logic       req_last_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_violation,
   output      logic [2:0] rsp_cause,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data
);

   // Config register.
   logic profile_ff;

   // Input register.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // Scan state.
   logic [2:0] script_pos_ff, script_pos_in;
   logic [3:0] scheme_pos_ff, scheme_pos_in;
   logic [2:0] iframe_pos_ff, iframe_pos_in;
   logic [2:0] object_pos_ff, object_pos_in;
   logic [2:0] embed_pos_ff, embed_pos_in;
   logic       inside_tag_ff, inside_tag_in;
   scf_pkg::handler_phase_type phase_ff, phase_in;
   logic       pending_ff, pending_in;
   logic [5:0] found_ff, found_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_violation_ff, rsp_violation_in;
   logic [2:0] rsp_cause_ff, rsp_cause_in;

   logic       req_take;
   logic       do_step;
   logic [7:0] c;
   logic [2:0] cause;
   scf_pkg::match_type m_script, m_scheme, m_iframe, m_object, m_embed;

   // A final byte can only move on when the response slot frees up.
   assign do_step   = s1_valid_ff && !(s1_last_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !do_step;
   assign req_take  = req_valid && !req_stall;
   assign s1_valid_in = req_take || (s1_valid_ff && !do_step);

   // Fold upper case letters.
   assign c = (s1_byte_ff >= 8'h41 && s1_byte_ff <= 8'h5a) ? (s1_byte_ff | 8'h20)
                                                           : s1_byte_ff;

   assign m_script = scf_pkg::match_step({1'b0, script_pos_ff}, c,
                                         scf_pkg::PAT_SCRIPT, scf_pkg::LEN_SCRIPT);
   assign m_scheme = scf_pkg::match_step(scheme_pos_ff, c,
                                         scf_pkg::PAT_SCHEME, scf_pkg::LEN_SCHEME);
   assign m_iframe = scf_pkg::match_step({1'b0, iframe_pos_ff}, c,
                                         scf_pkg::PAT_IFRAME, scf_pkg::LEN_IFRAME);
   assign m_object = scf_pkg::match_step({1'b0, object_pos_ff}, c,
                                         scf_pkg::PAT_OBJECT, scf_pkg::LEN_OBJECT);
   assign m_embed  = scf_pkg::match_step({1'b0, embed_pos_ff}, c,
                                         scf_pkg::PAT_EMBED, scf_pkg::LEN_EMBED);

   always_comb begin
      logic [5:0] found;
      logic       hit;
      scf_pkg::handler_phase_type ph;

      found = found_ff;
      hit   = 1'b0;
      ph    = scf_pkg::PH_IDLE;

      found[0] = found[0] | m_script.hit;
      found[2] = found[2] | m_iframe.hit;
      found[3] = found[3] | m_object.hit;
      found[4] = found[4] | m_embed.hit;

      // Scheme matcher skips whitespace and NUL bytes.
      scheme_pos_in = scheme_pos_ff;
      if (!scf_pkg::is_ws(c) && c != scf_pkg::CH_NUL) begin
         scheme_pos_in = m_scheme.pos;
         found[1]      = found[1] | m_scheme.hit;
      end

      script_pos_in = m_script.pos[2:0];
      iframe_pos_in = m_iframe.pos[2:0];
      object_pos_in = m_object.pos[2:0];
      embed_pos_in  = m_embed.pos[2:0];

      // Handler recognizer.
      case (phase_ff)
         scf_pkg::PH_WS: begin
            if (scf_pkg::is_ws(c))      ph = scf_pkg::PH_WS;
            else if (c == scf_pkg::CH_O) ph = scf_pkg::PH_O;
         end
         scf_pkg::PH_O: begin
            if (c == scf_pkg::CH_N)     ph = scf_pkg::PH_ON;
            else if (scf_pkg::is_ws(c)) ph = scf_pkg::PH_WS;
         end
         scf_pkg::PH_ON: begin
            if (scf_pkg::is_alpha(c))   ph = scf_pkg::PH_NAME;
            else if (scf_pkg::is_ws(c)) ph = scf_pkg::PH_WS;
         end
         scf_pkg::PH_NAME: begin
            if (scf_pkg::is_name_char(c)) ph = scf_pkg::PH_NAME;
            else if (scf_pkg::is_ws(c))   ph = scf_pkg::PH_POSTWS;
            else if (c == scf_pkg::CH_EQ) hit = 1'b1;
         end
         scf_pkg::PH_POSTWS: begin
            if (scf_pkg::is_ws(c))        ph = scf_pkg::PH_POSTWS;
            else if (c == scf_pkg::CH_EQ) hit = 1'b1;
            else if (c == scf_pkg::CH_O)  ph = scf_pkg::PH_O;
         end
         default: begin
            if (scf_pkg::is_ws(c)) ph = scf_pkg::PH_WS;
         end
      endcase

      inside_tag_in = inside_tag_ff;
      phase_in      = phase_ff;
      pending_in    = pending_ff;
      if (inside_tag_ff) begin
         if (c == scf_pkg::CH_GT) begin
            // Tag closed: a handler seen inside it now counts.
            found[5]      = found[5] | pending_ff;
            inside_tag_in = 1'b0;
            pending_in    = 1'b0;
            phase_in      = scf_pkg::PH_IDLE;
         end else begin
            phase_in   = ph;
            pending_in = pending_ff | hit;
         end
      end else if (c == scf_pkg::CH_LT) begin
         inside_tag_in = 1'b1;
         pending_in    = 1'b0;
         phase_in      = scf_pkg::PH_IDLE;
      end

      // Priority pick, lowest cause first.
      cause = scf_pkg::CAUSE_NONE;
      if (profile_ff) begin
         if (found[0])      cause = scf_pkg::CAUSE_SCRIPT;
         else if (found[1]) cause = scf_pkg::CAUSE_SCHEME;
         else if (found[2]) cause = scf_pkg::CAUSE_IFRAME;
         else if (found[3]) cause = scf_pkg::CAUSE_OBJECT;
         else if (found[4]) cause = scf_pkg::CAUSE_EMBED;
         else if (found[5]) cause = scf_pkg::CAUSE_HANDLER;
      end
      found_in = found;

      // End of document: back to a clean scan state.
      if (s1_last_ff) begin
         script_pos_in = 3'd0;
         scheme_pos_in = 4'd0;
         iframe_pos_in = 3'd0;
         object_pos_in = 3'd0;
         embed_pos_in  = 3'd0;
         inside_tag_in = 1'b0;
         phase_in      = scf_pkg::PH_IDLE;
         pending_in    = 1'b0;
         found_in      = 6'd0;
      end
   end

   // Response slot: loads on a final byte, drains when not stalled.
   assign rsp_valid_in     = (do_step && s1_last_ff) || (rsp_valid_ff && rsp_stall);
   assign rsp_violation_in = (cause != scf_pkg::CAUSE_NONE);
   assign rsp_cause_in     = cause;

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff    <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         script_pos_ff <= 3'd0;
         scheme_pos_ff <= 4'd0;
         iframe_pos_ff <= 3'd0;
         object_pos_ff <= 3'd0;
         embed_pos_ff  <= 3'd0;
         inside_tag_ff <= 1'b0;
         phase_ff      <= scf_pkg::PH_IDLE;
         pending_ff    <= 1'b0;
         found_ff      <= 6'd0;
      end else begin
         if (csr_wr_en) begin
            profile_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_step) begin
            script_pos_ff <= script_pos_in;
            scheme_pos_ff <= scheme_pos_in;
            iframe_pos_ff <= iframe_pos_in;
            object_pos_ff <= object_pos_in;
            embed_pos_ff  <= embed_pos_in;
            inside_tag_ff <= inside_tag_in;
            phase_ff      <= phase_in;
            pending_ff    <= pending_in;
            found_ff      <= found_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_doc_byte;
         s1_last_ff <= req_last_byte;
      end
      if (do_step && s1_last_ff) begin
         rsp_violation_ff <= rsp_violation_in;
         rsp_cause_ff     <= rsp_cause_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_violation = rsp_violation_ff;
   assign rsp_cause     = rsp_cause_ff;

   `SCF_ASSERT(a_viol_cause,
      rsp_valid_ff |-> (rsp_violation_ff == (rsp_cause_ff != scf_pkg::CAUSE_NONE)),
      "violation flag disagrees with cause")
   `SCF_ASSERT(a_stall_only_last,
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff),
      "input stalled without a blocked final byte")
   `SCF_ASSERT(a_profile_off,
      (do_step && s1_last_ff && !profile_ff) |=> !rsp_violation_ff,
      "violation reported with profile off")
   `SCF_ASSERT(a_doc_clear,
      (do_step && s1_last_ff) |=> (found_ff == 6'd0 && !inside_tag_ff && !pending_ff),
      "scan state not cleared after final byte")
   `SCF_ASSERT_ALWAYS(a_reset_idle,
      reset |=> (!rsp_valid_ff && !s1_valid_ff),
      "pipeline not empty after reset")

endmodule

`default_nettype wire

// File: tb/sv/script_content_filter_unit_tb.sv
`default_nettype none

module script_content_filter_unit_tb;

   localparam int ITEM_GOAL   = 800;       // random request bytes
   localparam int DOC_GOAL    = 40;        // random documents, at least
   localparam int PHASE_BYTES = 150;
   localparam int SETTLE      = 4;         // settling time after the last verdict
   localparam int DRAIN_LIMIT = 2000;
   localparam int RUN_LIMIT   = 8_000_000; // time units, far past a slow pass
   localparam int BY_MODEL    = -1;        // table row with no typed verdict
   localparam int PROBE_COUNT = 23;

   typedef struct packed {
      logic       violation;
      logic [2:0] cause;
   } verdict_type;

   typedef struct {
      bit    profile;
      string text;
      int    pin;
   } probe_type;

   // DUT ports; every input starts at a known value
   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_doc_byte  = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_stall     = 1'b0;
   logic       csr_wr_en     = 1'b0;
   logic       csr_wr_data   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_violation;
   logic [2:0] rsp_cause;

   // scoreboard copy of the filter state
   string             rule_text [scf_pkg::CAUSE_SCRIPT:scf_pkg::CAUSE_EMBED] =
      '{"<script", "javascript:", "<iframe", "<object", "<embed"}; // cause order
   logic [3:0]        rule_pos  [scf_pkg::CAUSE_SCRIPT:scf_pkg::CAUSE_EMBED];
   logic [5:0]        rules_hit;     // bit (cause - 1)
   logic              in_tag;
   logic              handler_armed; // handler seen in the open tag
   scf_pkg::handler_phase_type tag_phase;
   logic              profile_on;

   verdict_type pending_verdicts [$];
   int          pinned_causes [$];   // typed verdicts for the table rows
   logic [7:0]  doc_text [$];
   bit          steady;              // phase with no idling on either side
   int          errors       = 0;
   int unsigned bytes_seen   = 0;
   int unsigned docs_seen    = 0;
   int unsigned writes_seen  = 0;
   int unsigned cause_tally [0:7] = '{default: 0};
   int unsigned rsp_hold;

   // Directed documents. "\001" stands for a NUL byte, which a string
   // literal cannot carry.
   probe_type probes [PROBE_COUNT] = '{
      '{1'b0, "<SCRIPT>alert(1)</script>", scf_pkg::CAUSE_NONE}, // profile off at reset
      '{1'b0, "\377", scf_pkg::CAUSE_NONE},
      '{1'b0, "\001", scf_pkg::CAUSE_NONE},
      '{1'b1, "a", scf_pkg::CAUSE_NONE},
      '{1'b1, "\377", scf_pkg::CAUSE_NONE},
      '{1'b1, "\001", scf_pkg::CAUSE_NONE},
      '{1'b1, "<ScRiPt src=x>", scf_pkg::CAUSE_SCRIPT},
      '{1'b1, "JaVa \t\001Script\n:x", scf_pkg::CAUSE_SCHEME},    // blanks and NUL skipped
      '{1'b1, "<iframe>", scf_pkg::CAUSE_IFRAME},
      '{1'b1, "<OBJECT data=x>", scf_pkg::CAUSE_OBJECT},
      '{1'b1, "<embed>", scf_pkg::CAUSE_EMBED},
      '{1'b1, "<a href=x onclick=y>", scf_pkg::CAUSE_HANDLER},
      '{1'b1, "<x\tONCLICK\013=\015z>", scf_pkg::CAUSE_HANDLER},
      '{1'b1, "<b <c onmouse-over_2=1>", scf_pkg::CAUSE_HANDLER}, // nested open bracket
      '{1'b1, "<a onload = x", scf_pkg::CAUSE_NONE},              // tag never closed
      '{1'b1, " onload=x>", scf_pkg::CAUSE_NONE},                 // not inside a tag
      '{1'b1, "<embed><script>", scf_pkg::CAUSE_SCRIPT},          // priority
      '{1'b1, "<object>java script:", scf_pkg::CAUSE_SCHEME},
      '{1'b1, "<scr<script", BY_MODEL},                           // matcher restart
      '{1'b1, "<p onx\014on1=2>", BY_MODEL},
      '{1'b1, "\200<\351mbed \377on\300=>", BY_MODEL},            // high bytes
      '{1'b1, "javascript</a>", BY_MODEL},
      '{1'b1, "<img src=x onerror=alert(1)>", scf_pkg::CAUSE_HANDLER}
   };

   script_content_filter_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_doc_byte  (req_doc_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_violation (rsp_violation),
      .rsp_cause     (rsp_cause),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // character classes, on folded bytes
   // ---------------------------------------------------------------
   function automatic bit is_blank(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return c >= "a" && c <= "z";
   endfunction

   function automatic bit is_word_char(input logic [7:0] c);
      return is_letter(c) || (c >= "0" && c <= "9") || c == "-" || c == "_";
   endfunction

   // one step of a prefix matcher; pattern's first char is unique in it
   function automatic logic [3:0] follow_prefix(input logic [3:0] pos, input logic [7:0] c,
                                                input string pat, output bit hit);
      logic [3:0] nxt;
      hit = 1'b0;
      if (pos < pat.len() && c == pat[pos]) nxt = pos + 4'd1;
      else nxt = (c == pat[0]) ? 4'd1 : 4'd0;
      if (nxt >= pat.len()) begin
         hit = 1'b1;
         nxt = 4'd0;
      end
      return nxt;
   endfunction

   function automatic void forget_document();
      for (int r = scf_pkg::CAUSE_SCRIPT; r <= scf_pkg::CAUSE_EMBED; r++) rule_pos[r] = 4'd0;
      rules_hit     = '0;
      in_tag        = 1'b0;
      handler_armed = 1'b0;
      tag_phase     = scf_pkg::PH_IDLE;
   endfunction

   // Screens one byte; returns 1 with the verdict when the byte ends a document.
   function automatic bit screen_byte(input logic [7:0] raw, input bit last,
                                      output verdict_type v);
      logic [7:0]                 c;
      bit                         hit;
      bit                         blank;
      scf_pkg::handler_phase_type nxt;
      c     = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
      blank = is_blank(c);
      v     = '0;
      for (int r = scf_pkg::CAUSE_SCRIPT; r <= scf_pkg::CAUSE_EMBED; r++) begin
         // the scheme matcher does not see blanks or NUL
         if (r != scf_pkg::CAUSE_SCHEME || !(blank || c == scf_pkg::CH_NUL)) begin
            rule_pos[r] = follow_prefix(rule_pos[r], c, rule_text[r], hit);
            if (hit) rules_hit[r - 1] = 1'b1;
         end
      end
      if (in_tag) begin
         if (c == scf_pkg::CH_GT) begin
            // a handler only counts once its tag closes
            if (handler_armed) rules_hit[scf_pkg::CAUSE_HANDLER - 1] = 1'b1;
            in_tag        = 1'b0;
            handler_armed = 1'b0;
            tag_phase     = scf_pkg::PH_IDLE;
         end else begin
            nxt = scf_pkg::PH_IDLE;
            case (tag_phase)
               scf_pkg::PH_WS:     if (blank) nxt = scf_pkg::PH_WS;
                                   else if (c == scf_pkg::CH_O) nxt = scf_pkg::PH_O;
               scf_pkg::PH_O:      if (c == scf_pkg::CH_N) nxt = scf_pkg::PH_ON;
                                   else if (blank) nxt = scf_pkg::PH_WS;
               scf_pkg::PH_ON:     if (is_letter(c)) nxt = scf_pkg::PH_NAME;
                                   else if (blank) nxt = scf_pkg::PH_WS;
               scf_pkg::PH_NAME:   if (is_word_char(c)) nxt = scf_pkg::PH_NAME;
                                   else if (blank) nxt = scf_pkg::PH_POSTWS;
                                   else if (c == scf_pkg::CH_EQ) handler_armed = 1'b1;
               scf_pkg::PH_POSTWS: if (blank) nxt = scf_pkg::PH_POSTWS;
                                   else if (c == scf_pkg::CH_EQ) handler_armed = 1'b1;
                                   else if (c == scf_pkg::CH_O) nxt = scf_pkg::PH_O;
               default:            if (blank) nxt = scf_pkg::PH_WS;
            endcase
            tag_phase = nxt;
         end
      end else if (c == scf_pkg::CH_LT) begin
         in_tag        = 1'b1;
         tag_phase     = scf_pkg::PH_IDLE;
         handler_armed = 1'b0;
      end
      if (!last) return 1'b0;
      // lowest cause code wins
      if (profile_on)
         for (int k = scf_pkg::CAUSE_HANDLER; k >= scf_pkg::CAUSE_SCRIPT; k--)
            if (rules_hit[k - 1]) v.cause = 3'(k);
      v.violation = (v.cause != scf_pkg::CAUSE_NONE);
      forget_document();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // pacing and document generation
   // ---------------------------------------------------------------
   function automatic int unsigned pause_len();
      if (steady || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 19);
   endfunction

   function automatic logic [7:0] pick_gap_byte(input bit allow_nul);
      int unsigned k;
      k = $urandom_range(allow_nul ? 0 : 1, 6);
      return (k == 0) ? scf_pkg::CH_NUL : (k == 6) ? 8'h20 : 8'(8 + k);
   endfunction

   function automatic logic [7:0] pick_name_byte(input bit letter_only);
      int unsigned k;
      k = $urandom_range(0, letter_only ? 51 : 63);
      if (k < 26) return 8'("a" + k);
      if (k < 52) return 8'("A" + k - 26);
      if (k < 62) return 8'("0" + k - 52);
      return (k == 62) ? 8'h2d : 8'h5f;
   endfunction

   task automatic append_byte(input logic [7:0] b);
      doc_text = {doc_text, b};
   endtask

   // first count chars of s in random case, blanks/NUL sprinkled if asked
   task automatic put_word(input string s, input int count, input bit sprinkle);
      logic [7:0] ch;
      for (int i = 0; i < count; i++) begin
         ch = s[i];
         if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) ch = ch - 8'd32;
         append_byte(ch);
         if (sprinkle && $urandom_range(0, 3) == 0) append_byte(pick_gap_byte(1'b1));
      end
   endtask

   task automatic compose_document();
      int unsigned r;
      int unsigned cut;
      doc_text.delete();
      // single-byte documents keep the response side busy
      if ($urandom_range(0, 7) == 0) begin
         append_byte(8'($urandom_range(0, 255)));
         return;
      end
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 11))
            0, 1: begin
               // one of the five patterns, now and then cut short
               r   = $urandom_range(scf_pkg::CAUSE_SCRIPT, scf_pkg::CAUSE_EMBED);
               cut = rule_text[r].len();
               if ($urandom_range(0, 2) == 0) cut = $urandom_range(1, cut - 1);
               put_word(rule_text[r], cut, r == scf_pkg::CAUSE_SCHEME);
            end
            2, 3, 4: begin
               // tag with an event attribute; any part may be malformed
               append_byte(scf_pkg::CH_LT);
               repeat ($urandom_range(0, 3)) append_byte(pick_name_byte(1'b1));
               repeat ($urandom_range(0, 2)) append_byte(pick_gap_byte(1'b0));
               put_word("on", ($urandom_range(0, 3) == 0) ? 1 : 2, 1'b0);
               append_byte(pick_name_byte($urandom_range(0, 5) != 0));
               repeat ($urandom_range(0, 5)) append_byte(pick_name_byte(1'b0));
               repeat ($urandom_range(0, 2)) append_byte(pick_gap_byte(1'b0));
               if ($urandom_range(0, 4) != 0) append_byte(scf_pkg::CH_EQ);
               repeat ($urandom_range(0, 3)) append_byte(pick_name_byte(1'b0));
               if ($urandom_range(0, 3) != 0) append_byte(scf_pkg::CH_GT);
            end
            5: append_byte(scf_pkg::CH_GT);
            6: append_byte(scf_pkg::CH_LT);
            7, 8: repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
            9: repeat ($urandom_range(1, 8))
                  append_byte(($urandom_range(0, 4) == 0) ? 8'h20 : pick_name_byte(1'b1));
            10: repeat ($urandom_range(1, 4)) append_byte(pick_gap_byte(1'b1));
            default: put_word(" onload=", $urandom_range(1, 8), 1'b0);
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // request side driver
   // ---------------------------------------------------------------
   task automatic send_document();
      int unsigned gap;
      for (int i = 0; i < doc_text.size(); i++) begin
         gap = pause_len();
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_doc_byte  <= doc_text[i];
         req_last_byte <= (i == doc_text.size() - 1);
         do @(posedge clock); while (req_stall);
      end
   endtask

   task automatic write_profile(input bit on);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // drop valid, let every verdict come back, then cover the pipeline
   task automatic wait_quiet();
      int spins;
      spins = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // response side: each response waits a drawn number of valid cycles
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_hold = pause_len();
         else if (rsp_valid && rsp_hold != 0) rsp_hold--;
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // ---------------------------------------------------------------
   // scoreboard: sample handshakes at the edge, pre-update values
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      int          pin;
      if (reset) begin
         profile_on = 1'b0;
         forget_document();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: response with nothing expected: violation=%0d cause=%0d",
                        $time, rsp_violation, rsp_cause);
               errors++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_violation !== want.violation) begin
                  $display("%0t: violation mismatch: expected %0d, actual %0d",
                           $time, want.violation, rsp_violation);
                  errors++;
               end
               if (rsp_cause !== want.cause) begin
                  $display("%0t: cause mismatch: expected %0d, actual %0d",
                           $time, want.cause, rsp_cause);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            bytes_seen++;
            if (screen_byte(req_doc_byte, req_last_byte, got)) begin
               // table rows with a typed verdict override the scoreboard
               if (pinned_causes.size() != 0) begin
                  pin = pinned_causes.pop_front();
                  if (pin != BY_MODEL) begin
                     got.cause     = 3'(pin);
                     got.violation = (pin != scf_pkg::CAUSE_NONE);
                  end
               end
               pending_verdicts = {pending_verdicts, got};
               cause_tally[got.cause]++;
               docs_seen++;
            end
         end
         if (csr_wr_en) begin
            profile_on = csr_wr_data;
            writes_seen++;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus sequence
   // ---------------------------------------------------------------
   initial begin
      bit profile_now;
      int rand_bytes;
      int rand_docs;
      int phase_start;
      int phase;
      profile_now = 1'b0;   // reset value, first rows rely on it
      rand_bytes  = 0;
      rand_docs   = 0;
      phase       = 0;
      steady      = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < PROBE_COUNT; i++) begin
         if (probes[i].profile != profile_now) begin
            wait_quiet();
            write_profile(probes[i].profile);
            profile_now = probes[i].profile;
         end
         doc_text.delete();
         for (int j = 0; j < probes[i].text.len(); j++)
            append_byte((probes[i].text[j] == 8'h01) ? scf_pkg::CH_NUL : probes[i].text[j]);
         pinned_causes = {pinned_causes, probes[i].pin};
         send_document();
      end

      // random phases; the second one always runs with the profile off
      while (rand_bytes < ITEM_GOAL || rand_docs < DOC_GOAL) begin
         wait_quiet();
         steady      = (phase % 3 == 2);
         profile_now = (phase == 1) ? 1'b0 : ($urandom_range(0, 4) != 0);
         write_profile(profile_now);
         phase_start = rand_bytes;
         while (rand_bytes - phase_start < PHASE_BYTES) begin
            compose_document();
            send_document();
            rand_bytes += doc_text.size();
            rand_docs++;
         end
         phase++;
      end

      wait_quiet();
      if (pending_verdicts.size() != 0) begin
         $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
         errors += pending_verdicts.size();
      end
      $display("Covered %0d request bytes, %0d documents, %0d phases, %0d profile writes",
               bytes_seen, docs_seen, phase, writes_seen);
      $display("Verdicts by cause 0..6: %0d %0d %0d %0d %0d %0d %0d",
               cause_tally[0], cause_tally[1], cause_tally[2], cause_tally[3],
               cause_tally[4], cause_tally[5], cause_tally[6]);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT);
      $display("%0t: run did not finish", $time);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
